### rtl/core/frcp_pkg.sv
// Package for the fault record character parser.
// Holds the record layout constants, result codes, shared types and the
// hex decode helper; depends on nothing else.
package frcp_pkg;

  localparam logic [4:0] PosLimit  = 5'd22;
  localparam logic [4:0] MinLen    = 5'd16;
  localparam logic [4:0] MsLen     = 5'd20;
  localparam logic [4:0] DateStart = 5'd2;
  localparam logic [4:0] TailStart = 5'd14;
  localparam logic [4:0] DurStart  = 5'd17;
  localparam logic [4:0] PendMax   = 5'd31;
  localparam int unsigned DateDigits = 12;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PIN_OUTPUT  = 2'd0,
    PIN_INPUT   = 2'd1,
    PIN_UNKNOWN = 2'd2
  } pin_kind_e;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_MS   = 2'd1,
    TAIL_BOTH = 2'd2
  } tail_e;

  // Parser state after the current character has been taken.
  typedef struct packed {
    logic [4:0]                       pos;
    logic                             fmt_bad;
    logic [7:0]                       pin;
    logic [DateDigits-1:0][3:0]       digits;
    logic [11:0]                      ms;
    logic [19:0]                      dur;
  } snap_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pin_number;
    pin_kind_e   pin_kind;
    logic [6:0]  year_two_digit;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [6:0]  hour_value;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
    logic [11:0] millisecond_value;
    logic [19:0] duration_q8_12;
    tail_e       tail_present;
  } rec_t;

  // Bit 4 flags a valid hex character, bits 3:0 carry its value (zero if not hex).
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

### rtl/core/frcp_if.sv
// Channel interfaces of the fault record character parser.
// One for the character beats and one for the record beats; no dependencies.
interface frcp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink (input valid, char_code, last, output ready);
endinterface

interface frcp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  pin_number;
  logic [1:0]  pin_kind;
  logic [6:0]  year_two_digit;
  logic [6:0]  month_value;
  logic [6:0]  day_value;
  logic [6:0]  hour_value;
  logic [6:0]  minute_value;
  logic [6:0]  second_value;
  logic [11:0] millisecond_value;
  logic [19:0] duration_q8_12;
  logic [1:0]  tail_present;

  modport source (output valid, status, pin_number, pin_kind, year_two_digit, month_value,
                  day_value, hour_value, minute_value, second_value, millisecond_value,
                  duration_q8_12, tail_present, input ready);
  modport sink (input valid, status, pin_number, pin_kind, year_two_digit, month_value,
                day_value, hour_value, minute_value, second_value, millisecond_value,
                duration_q8_12, tail_present, output ready);
endinterface

### rtl/core/fault_record_char_parser_top.sv
// Top level of the fault record character parser.
// Depends on frcp_pkg, frcp_if, frcp_accum and frcp_record.
//
//   Channel  Direction  Beat carries
//   char_i   in         one text character and the final-character flag
//   rec_o    out        one parsed fault record per final character
//
// A beat is taken every cycle while no final character stalls; it is registered
// in the input register, then parser state and record update in one pass.
// A record is registered when its final character leaves the input register.
// The record register holds a record until it is taken; only a final character
// waits in the input register while that register is full.
// Reset is asynchronous and clears the parser state and both valid flags.
module fault_record_char_parser_top import frcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  frcp_char_if.sink  char_i,
  frcp_rec_if.source rec_o
);

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       out_valid_q;
  rec_t       out_q;
  rec_t       rec_d;
  snap_t      snap;
  logic       out_free;
  logic       s1_fire;
  logic       in_ready;

  assign out_free = !out_valid_q || rec_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready = !s1_valid_q || s1_fire;

  assign char_i.ready = in_ready;

  frcp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .char_code_i (s1_char_q),
    .last_i      (s1_last_q),
    .snap_o      (snap)
  );

  frcp_record u_record (
    .snap_i (snap),
    .rec_o  (rec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= char_i.valid;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (rec_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && char_i.valid) begin
      s1_char_q <= char_i.char_code;
      s1_last_q <= char_i.last;
    end
    if (s1_fire && s1_last_q) begin
      out_q <= rec_d;
    end
  end

  assign rec_o.valid             = out_valid_q;
  assign rec_o.status            = out_q.status;
  assign rec_o.pin_number        = out_q.pin_number;
  assign rec_o.pin_kind          = out_q.pin_kind;
  assign rec_o.year_two_digit    = out_q.year_two_digit;
  assign rec_o.month_value       = out_q.month_value;
  assign rec_o.day_value         = out_q.day_value;
  assign rec_o.hour_value        = out_q.hour_value;
  assign rec_o.minute_value      = out_q.minute_value;
  assign rec_o.second_value      = out_q.second_value;
  assign rec_o.millisecond_value = out_q.millisecond_value;
  assign rec_o.duration_q8_12    = out_q.duration_q8_12;
  assign rec_o.tail_present      = out_q.tail_present;

`ifndef SYNTHESIS
  a_format_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_FORMAT |->
      out_q.pin_number == 8'd0 && out_q.pin_kind == PIN_UNKNOWN &&
      out_q.month_value == 7'd0 && out_q.tail_present == TAIL_NONE)
    else $error("bad-format record carries field data");

  a_range_no_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_RANGE |->
      out_q.tail_present == TAIL_NONE && out_q.millisecond_value == 12'd0 &&
      out_q.duration_q8_12 == 20'd0)
    else $error("out-of-range record carries a tail");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_char_q) && $stable(s1_last_q))
    else $error("stalled character lost from the input register");
`endif

endmodule

### rtl/core/frcp_accum.sv
// Parser state and its per-character update for the fault record parser.
// Depends on frcp_pkg; presents the state after the current character.
module frcp_accum import frcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  output snap_t      snap_o
);

  logic [4:0]                 pos_q, pos_d;
  logic                       started_q, started_d;
  logic [4:0]                 pend_q, pend_d;
  logic                       bad_q, bad_d;
  logic [7:0]                 pin_q, pin_d;
  logic [DateDigits-1:0][3:0] digits_q, digits_d;
  logic [11:0]                ms_q, ms_d;
  logic [19:0]                dur_q, dur_d;

  function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] lo,
                                        input logic [4:0] hi);
    logic [4:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic       is_ws;
  logic       is_digit;
  logic [4:0] hex;
  logic [5:0] pend_sum;
  logic [4:0] pe;
  logic [1:0] n_ms;
  logic [2:0] n_dur;
  logic [3:0] date_idx;

  assign is_ws    = (char_code_i == 8'd32) || (char_code_i >= 8'd9 && char_code_i <= 8'd13);
  assign is_digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign hex      = hex_decode(char_code_i);
  assign pend_sum = {1'b0, pos_q} + {1'b0, pend_q};
  assign pe       = (pend_sum > {1'b0, PosLimit}) ? PosLimit : pend_sum[4:0];
  assign n_ms     = 2'(clamp5(pe, TailStart, DurStart) - clamp5(pos_q, TailStart, DurStart));
  assign n_dur    = 3'(clamp5(pe, DurStart, PosLimit) - clamp5(pos_q, DurStart, PosLimit));
  assign date_idx = 4'(pe - DateStart);

  always_comb begin
    pos_d     = pos_q;
    started_d = started_q;
    pend_d    = pend_q;
    bad_d     = bad_q;
    pin_d     = pin_q;
    digits_d  = digits_q;
    ms_d      = ms_q;
    dur_d     = dur_q;
    if (step_i) begin
      if (is_ws) begin
        if (started_q && pend_q != PendMax) begin
          pend_d = 5'(pend_q + 5'd1);
        end
      end else begin
        // Held spaces take their positions first; in the tail they are zero digits.
        started_d = 1'b1;
        pend_d    = 5'd0;
        if (pend_q != 5'd0 && pos_q < TailStart) begin
          bad_d = 1'b1;
        end
        ms_d  = ms_q << {n_ms, 2'b00};
        dur_d = dur_q << {n_dur, 2'b00};
        pos_d = pe;
        if (pe < PosLimit) begin
          pos_d = 5'(pe + 5'd1);
          if (pe < DateStart) begin
            bad_d = bad_d | ~hex[4];
            pin_d = {pin_q[3:0], hex[3:0]};
          end else if (pe < TailStart) begin
            digits_d[date_idx] = is_digit ? char_code_i[3:0] : 4'd0;
            bad_d = bad_d | ~is_digit;
          end else if (pe < DurStart) begin
            ms_d = {ms_d[7:0], hex[3:0]};
          end else begin
            dur_d = {dur_d[15:0], hex[3:0]};
          end
        end
      end
    end
  end

  assign snap_o = '{pos: pos_d, fmt_bad: bad_d, pin: pin_d, digits: digits_d,
                    ms: ms_d, dur: dur_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      started_q <= 1'b0;
      pend_q    <= '0;
      bad_q     <= 1'b0;
      pin_q     <= '0;
      digits_q  <= '0;
      ms_q      <= '0;
      dur_q     <= '0;
    end else if (step_i && last_i) begin
      pos_q     <= '0;
      started_q <= 1'b0;
      pend_q    <= '0;
      bad_q     <= 1'b0;
      pin_q     <= '0;
      digits_q  <= '0;
      ms_q      <= '0;
      dur_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      started_q <= started_d;
      pend_q    <= pend_d;
      bad_q     <= bad_d;
      pin_q     <= pin_d;
      digits_q  <= digits_d;
      ms_q      <= ms_d;
      dur_q     <= dur_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLimit)
    else $error("character position beyond the record layout");

  a_pend_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 5'd0 |-> started_q)
    else $error("spaces held before any text");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == 5'd0 && !started_q && pend_q == 5'd0 && !bad_q)
    else $error("parser state not cleared after the final character");
`endif

endmodule

### rtl/core/frcp_record.sv
// Record assembly for the fault record parser: date-time fields, checks and tail.
// Depends on frcp_pkg; purely combinational from the parser state.
module frcp_record import frcp_pkg::*; (
  input  snap_t snap_i,
  output rec_t  rec_o
);

  function automatic logic [7:0] two_digits(input logic [3:0] a, input logic [3:0] b);
    logic [7:0] r;
    r = 8'({4'd0, a} * 8'd10) + {4'd0, b};
    return r;
  endfunction

  logic [7:0] yy, mo, dd, hh, mi, ss;
  logic       fmt_bad;
  logic       range_bad;
  pin_kind_e  kind;

  assign yy = two_digits(snap_i.digits[0], snap_i.digits[1]);
  assign mo = two_digits(snap_i.digits[2], snap_i.digits[3]);
  assign dd = two_digits(snap_i.digits[4], snap_i.digits[5]);
  assign hh = two_digits(snap_i.digits[6], snap_i.digits[7]);
  assign mi = two_digits(snap_i.digits[8], snap_i.digits[9]);
  assign ss = two_digits(snap_i.digits[10], snap_i.digits[11]);

  assign fmt_bad   = snap_i.fmt_bad || (snap_i.pos < MinLen);
  assign range_bad = (mo < 8'd1) || (mo > 8'd12) || (dd < 8'd1) || (dd > 8'd31) ||
                     (hh > 8'd23) || (mi > 8'd59) || (ss > 8'd59);

  always_comb begin
    if (snap_i.pin >= 8'd1 && snap_i.pin <= 8'd8) begin
      kind = PIN_OUTPUT;
    end else if (snap_i.pin >= 8'd9 && snap_i.pin <= 8'd16) begin
      kind = PIN_INPUT;
    end else begin
      kind = PIN_UNKNOWN;
    end
  end

  always_comb begin
    rec_o = '{status: STATUS_OK, pin_kind: PIN_UNKNOWN, tail_present: TAIL_NONE,
              default: '0};
    if (fmt_bad) begin
      rec_o.status = STATUS_FORMAT;
    end else begin
      rec_o.pin_number     = snap_i.pin;
      rec_o.pin_kind       = kind;
      rec_o.year_two_digit = yy[6:0];
      rec_o.month_value    = mo[6:0];
      rec_o.day_value      = dd[6:0];
      rec_o.hour_value     = hh[6:0];
      rec_o.minute_value   = mi[6:0];
      rec_o.second_value   = ss[6:0];
      if (range_bad) begin
        rec_o.status = STATUS_RANGE;
      end else if (snap_i.pos >= PosLimit) begin
        rec_o.millisecond_value = snap_i.ms;
        rec_o.duration_q8_12    = snap_i.dur;
        rec_o.tail_present      = TAIL_BOTH;
      end else if (snap_i.pos >= MsLen) begin
        rec_o.millisecond_value = snap_i.ms;
        rec_o.tail_present      = TAIL_MS;
      end
    end
  end

endmodule

### test/frcp_checker.sv
`timescale 1ns / 100ps
// Record checker for the fault record character parser test bench.
// Watches the character and record channels, keeps its own parser state and
// compares every record beat; depends on frcp_pkg and frcp_if.
module frcp_checker import frcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  frcp_char_if        char_mon,
  frcp_rec_if         rec_mon,
  output int unsigned errors_o,
  output int unsigned waiting_o,
  output int unsigned n_ok_o,
  output int unsigned n_format_o,
  output int unsigned n_range_o
);

  logic [4:0]  pos_q;
  logic [4:0]  spaces_q;
  logic        started_q;
  logic        fmt_bad_q;
  logic [7:0]  pin_acc;
  logic [3:0]  digits_q [DateDigits];
  logic [11:0] ms_acc;
  logic [19:0] dur_acc;
  rec_t        records_due [$];

  int unsigned n_err     = 0;
  int unsigned n_waiting = 0;
  int unsigned n_ok      = 0;
  int unsigned n_format  = 0;
  int unsigned n_range   = 0;

  assign errors_o   = n_err;
  assign waiting_o  = n_waiting;
  assign n_ok_o     = n_ok;
  assign n_format_o = n_format;
  assign n_range_o  = n_range;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c, output logic ok);
    ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      return 4'(c - 8'h30);
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return 4'(c - 8'h41 + 8'd10);
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return 4'(c - 8'h61 + 8'd10);
    end
    ok = 1'b0;
    return 4'd0;
  endfunction

  function automatic logic [6:0] pair(input int i);
    return 7'(int'(digits_q[i]) * 10 + int'(digits_q[i + 1]));
  endfunction

  task automatic clear_parser();
    pos_q     = 5'd0;
    spaces_q  = 5'd0;
    started_q = 1'b0;
    fmt_bad_q = 1'b0;
    pin_acc   = 8'd0;
    ms_acc    = 12'd0;
    dur_acc   = 20'd0;
    for (int i = 0; i < DateDigits; i++) begin
      digits_q[i] = 4'd0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic       ok;
    logic [3:0] h;
    if (pos_q >= PosLimit) begin
      return;
    end
    h = nibble_of(c, ok);
    if (pos_q < DateStart) begin
      if (!ok) begin
        fmt_bad_q = 1'b1;
      end
      pin_acc = {pin_acc[3:0], h};
    end else if (pos_q < TailStart) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        digits_q[pos_q - DateStart] = c[3:0];
      end else begin
        fmt_bad_q = 1'b1;
        digits_q[pos_q - DateStart] = 4'd0;
      end
    end else if (pos_q < DurStart) begin
      ms_acc = {ms_acc[7:0], h};
    end else begin
      dur_acc = {dur_acc[15:0], h};
    end
    pos_q = pos_q + 5'd1;
  endtask

  function automatic rec_t record_now();
    rec_t r;
    r = '0;
    if (pos_q < MinLen || fmt_bad_q) begin
      r.status   = STATUS_FORMAT;
      r.pin_kind = PIN_UNKNOWN;
      return r;
    end
    r.pin_number = pin_acc;
    if (pin_acc >= 8'd1 && pin_acc <= 8'd8) begin
      r.pin_kind = PIN_OUTPUT;
    end else if (pin_acc >= 8'd9 && pin_acc <= 8'd16) begin
      r.pin_kind = PIN_INPUT;
    end else begin
      r.pin_kind = PIN_UNKNOWN;
    end
    r.year_two_digit = pair(0);
    r.month_value    = pair(2);
    r.day_value      = pair(4);
    r.hour_value     = pair(6);
    r.minute_value   = pair(8);
    r.second_value   = pair(10);
    if (r.month_value < 7'd1 || r.month_value > 7'd12 || r.day_value < 7'd1 ||
        r.day_value > 7'd31 || r.hour_value > 7'd23 || r.minute_value > 7'd59 ||
        r.second_value > 7'd59) begin
      r.status = STATUS_RANGE;
    end else begin
      r.status = STATUS_OK;
      if (pos_q >= PosLimit) begin
        r.millisecond_value = ms_acc;
        r.duration_q8_12    = dur_acc;
        r.tail_present      = TAIL_BOTH;
      end else if (pos_q >= MsLen) begin
        r.millisecond_value = ms_acc;
        r.tail_present      = TAIL_MS;
      end
    end
    return r;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic lst);
    if (!is_blank(c)) begin
      if (started_q) begin
        while (spaces_q != 5'd0) begin
          take_char(8'h20);
          spaces_q = spaces_q - 5'd1;
        end
      end
      started_q = 1'b1;
      take_char(c);
    end else if (started_q && spaces_q < PendMax) begin
      spaces_q = spaces_q + 5'd1;
    end
    if (lst) begin
      records_due.push_back(record_now());
      clear_parser();
    end
  endtask

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    rec_t want;
    if (!rst_ni) begin
      clear_parser();
      records_due.delete();
    end else begin
      if (char_mon.valid && char_mon.ready) begin
        parse_char(char_mon.char_code, char_mon.last);
      end
      if (rec_mon.valid && rec_mon.ready) begin
        if (records_due.size() == 0) begin
          $error("record beat arrived with no record outstanding");
          n_err++;
        end else begin
          want = records_due.pop_front();
          compare("status", want.status, rec_mon.status);
          compare("pin_number", want.pin_number, rec_mon.pin_number);
          compare("pin_kind", want.pin_kind, rec_mon.pin_kind);
          compare("year_two_digit", want.year_two_digit, rec_mon.year_two_digit);
          compare("month_value", want.month_value, rec_mon.month_value);
          compare("day_value", want.day_value, rec_mon.day_value);
          compare("hour_value", want.hour_value, rec_mon.hour_value);
          compare("minute_value", want.minute_value, rec_mon.minute_value);
          compare("second_value", want.second_value, rec_mon.second_value);
          compare("millisecond_value", want.millisecond_value, rec_mon.millisecond_value);
          compare("duration_q8_12", want.duration_q8_12, rec_mon.duration_q8_12);
          compare("tail_present", want.tail_present, rec_mon.tail_present);
          case (want.status)
            STATUS_OK: begin
              n_ok++;
            end
            STATUS_FORMAT: begin
              n_format++;
            end
            default: begin
              n_range++;
            end
          endcase
        end
      end
    end
    n_waiting = records_due.size();
  end

endmodule

### test/tb_fault_record_char_parser_top.sv
`timescale 1ns / 100ps
// Top of the fault record character parser test bench.
// Drives directed and random record texts with random gaps and back-pressure;
// depends on frcp_pkg, frcp_if, frcp_checker and the parser top level.
module tb_fault_record_char_parser_top;
  import frcp_pkg::*;

  typedef enum int {
    SHAPE_VALID,
    SHAPE_RANGE,
    SHAPE_BAD_PIN,
    SHAPE_BAD_DIGIT,
    SHAPE_SHORT,
    SHAPE_NOISE
  } line_shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet  = 1'b0;

  int unsigned errors;
  int unsigned waiting;
  int unsigned n_ok;
  int unsigned n_format;
  int unsigned n_range;
  int unsigned n_sent = 0;
  logic [7:0]  line_q [$];

  frcp_char_if char_bus ();
  frcp_rec_if  rec_bus ();

  fault_record_char_parser_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .rec_o  (rec_bus)
  );

  frcp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_mon   (char_bus),
    .rec_mon    (rec_bus),
    .errors_o   (errors),
    .waiting_o  (waiting),
    .n_ok_o     (n_ok),
    .n_format_o (n_format),
    .n_range_o  (n_range)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned v;
    v = $urandom_range(5);
    return (v == 5) ? 8'h20 : 8'(8'h09 + v);
  endfunction

  // A byte value that is neither blank nor a decimal digit,
  // and with hex_too set, not a hex letter either.
  function automatic logic [7:0] junk_char(input bit hex_too);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (is_space(c) || (c >= 8'h30 && c <= 8'h39) ||
               (hex_too && ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))));
    return c;
  endfunction

  task automatic push_hex(input int unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      line_q.push_back(hex_char((v >> (4 * i)) & 15));
    end
  endtask

  task automatic push_dec2(input int unsigned v);
    line_q.push_back(8'(8'h30 + v / 10));
    line_q.push_back(8'(8'h30 + v % 10));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
  endtask

  function automatic line_shape_e pick_shape();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) begin
      return SHAPE_VALID;
    end else if (r < 62) begin
      return SHAPE_RANGE;
    end else if (r < 70) begin
      return SHAPE_BAD_PIN;
    end else if (r < 78) begin
      return SHAPE_BAD_DIGIT;
    end else if (r < 88) begin
      return SHAPE_SHORT;
    end
    return SHAPE_NOISE;
  endfunction

  task automatic build_line(input line_shape_e shape);
    int unsigned fields [6];
    int unsigned bad;
    int unsigned at;
    int unsigned run;
    line_q.delete();
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(30, 1)) begin
        line_q.push_back(8'($urandom_range(255)));
      end
      return;
    end
    push_hex(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(17), 2);
    fields[0] = $urandom_range(99);
    fields[1] = $urandom_range(12, 1);
    fields[2] = $urandom_range(31, 1);
    fields[3] = $urandom_range(23);
    fields[4] = $urandom_range(59);
    fields[5] = $urandom_range(59);
    if (shape == SHAPE_RANGE) begin
      bad = $urandom_range(5, 1);
      case (bad)
        1: begin
          fields[1] = $urandom_range(1) ? 0 : $urandom_range(99, 13);
        end
        2: begin
          fields[2] = $urandom_range(1) ? 0 : $urandom_range(99, 32);
        end
        3: begin
          fields[3] = $urandom_range(99, 24);
        end
        default: begin
          fields[bad] = $urandom_range(99, 60);
        end
      endcase
    end
    foreach (fields[i]) begin
      push_dec2(fields[i]);
    end
    repeat ($urandom_range(10)) begin
      line_q.push_back(($urandom_range(11) == 0) ? junk_char(1'b1) : hex_char($urandom_range(15)));
    end
    if (shape == SHAPE_BAD_PIN) begin
      line_q[$urandom_range(1)] = junk_char(1'b1);
    end else if (shape == SHAPE_BAD_DIGIT) begin
      line_q[$urandom_range(13, 2)] = junk_char(1'b0);
    end else if (shape == SHAPE_SHORT) begin
      at = $urandom_range(15, 1);
      while (line_q.size() > at) begin
        void'(line_q.pop_back());
      end
    end
    if (line_q.size() > 1 && $urandom_range(3) == 0) begin
      at  = (line_q.size() > 15) ? $urandom_range(line_q.size() - 1, 14)
                                 : $urandom_range(line_q.size() - 1, 1);
      run = ($urandom_range(19) == 0) ? 40 : $urandom_range(3, 1);
      repeat (run) begin
        line_q.insert(at, blank_char());
      end
    end
    repeat ($urandom_range(2)) begin
      line_q.push_front(blank_char());
    end
    repeat ($urandom_range(2)) begin
      line_q.push_back(blank_char());
    end
  endtask

  // Called and left at a falling edge; valid is written once per step.
  task automatic send_char(input logic [7:0] c, input logic lst);
    while (!quiet && $urandom_range(99) < 11) begin
      char_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last      <= lst;
    @(posedge clk_i);
    while (!char_bus.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_char(line_q[i], i == line_q.size() - 1);
    end
  endtask

  task automatic wait_drained();
    char_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (waiting != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    rec_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rec_bus.ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  initial begin
    int unsigned n_lines;
    char_bus.valid     = 1'b0;
    char_bus.char_code = 8'h00;
    char_bus.last      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A text of one blank only, then a one-character text with the top bit set.
    line_q = '{8'h09};
    send_line();
    line_q = '{8'hff};
    send_line();
    // Extreme date and time, pin 16, blank inside the duration, text past the
    // last position and a trailing blank on the final beat.
    line_q.delete();
    push_text(" 10991231235959FFF\tfF123 ");
    send_line();

    n_lines = 0;
    while (n_sent < 1050) begin
      quiet = (n_sent >= 400 && n_sent < 600);
      if (n_lines == 15) begin
        wait_drained();
      end
      build_line(pick_shape());
      send_line();
      n_lines++;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d characters in %0d random lines; records checked: %0d valid,",
             n_sent, n_lines, n_ok);
    $display("%0d bad format, %0d bad date-time.", n_format, n_range);
    if (errors == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
